FILE: rtl/encoder_unwrap_window_velocity_assert.svh
// Assertion macros shared by the checker.
`ifndef ENCODER_UNWRAP_WINDOW_VELOCITY_ASSERT_SVH
`define ENCODER_UNWRAP_WINDOW_VELOCITY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EUWV_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EUWV_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

FILE: rtl/euwv_pkg.sv
package euwv_pkg;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_W    = 12;
    localparam int DELTA_W     = 13;
    localparam int ANGLE_W     = 32;
    localparam int WSUM_W      = 16;
    localparam int VEL_W       = 25;
    localparam int SCALE_W     = 10;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int HALF_TURN   = 2048;
    localparam int TURN        = 4096;
    localparam int SCALE_RESET = 200;

    localparam logic REG_VELOCITY_SCALE = 1'b0;

    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SUM_W      = $clog2(WINDOW * HALF_TURN + 1) + 1;
    localparam int SUM_EXT_W  = (SUM_W > WSUM_W) ? SUM_W : WSUM_W + 1;
    localparam int PROD_W     = SUM_W + SCALE_W + 1;
    localparam int PROD_EXT_W = (PROD_W > VEL_W) ? PROD_W : VEL_W + 1;

    function automatic logic signed [DELTA_W-1:0] wrap_delta(
        input logic [SAMPLE_W-1:0] cur,
        input logic [SAMPLE_W-1:0] prev
    );
        logic signed [DELTA_W:0] diff;
        begin
            diff = $signed({2'b00, cur}) - $signed({2'b00, prev});
            if (diff < -(DELTA_W + 1)'(HALF_TURN))
            begin
                diff = diff + (DELTA_W + 1)'(TURN);
            end
            else if (diff > (DELTA_W + 1)'(HALF_TURN))
            begin
                diff = diff - (DELTA_W + 1)'(TURN);
            end
            wrap_delta = diff[DELTA_W-1:0];
        end
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat_angle(
        input logic signed [ANGLE_W-1:0] angle,
        input logic signed [DELTA_W-1:0] delta
    );
        logic signed [ANGLE_W:0] sum;
        begin
            sum = (ANGLE_W + 1)'(angle) + (ANGLE_W + 1)'(delta);
            if (sum[ANGLE_W] != sum[ANGLE_W-1])
            begin
                sat_angle = {sum[ANGLE_W], {(ANGLE_W - 1){~sum[ANGLE_W]}}};
            end
            else
            begin
                sat_angle = sum[ANGLE_W-1:0];
            end
        end
    endfunction

    function automatic logic signed [WSUM_W-1:0] sat_wsum(
        input logic signed [SUM_W-1:0] total
    );
        logic signed [SUM_EXT_W-1:0] ext;
        logic signed [SUM_EXT_W-1:0] hi;
        logic signed [SUM_EXT_W-1:0] lo;
        begin
            ext = SUM_EXT_W'(total);
            hi  = SUM_EXT_W'((1 << (WSUM_W - 1)) - 1);
            lo  = -SUM_EXT_W'(1 << (WSUM_W - 1));
            if (ext > hi)
            begin
                ext = hi;
            end
            else if (ext < lo)
            begin
                ext = lo;
            end
            sat_wsum = ext[WSUM_W-1:0];
        end
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_EXT_W-1:0] ext;
        logic signed [PROD_EXT_W-1:0] hi;
        logic signed [PROD_EXT_W-1:0] lo;
        begin
            ext = PROD_EXT_W'(prod);
            hi  = PROD_EXT_W'((1 << (VEL_W - 1)) - 1);
            lo  = -PROD_EXT_W'(1 << (VEL_W - 1));
            if (ext > hi)
            begin
                ext = hi;
            end
            else if (ext < lo)
            begin
                ext = lo;
            end
            sat_vel = ext[VEL_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/euwv_cell.sv
module euwv_cell (
    input  logic                                 clk,
    input  logic                                 shift,
    input  logic signed [euwv_pkg::DELTA_W-1:0]  delta_in,
    output logic signed [euwv_pkg::DELTA_W-1:0]  delta_out
);

    logic signed [euwv_pkg::DELTA_W-1:0] delta_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            delta_reg <= delta_in;
        end
    end

    assign delta_out = delta_reg;

endmodule

FILE: rtl/euwv_chain.sv
module euwv_chain (
    input  logic                                 clk,
    input  logic                                 shift,
    input  logic signed [euwv_pkg::DELTA_W-1:0]  delta_in,
    output logic signed [euwv_pkg::DELTA_W-1:0]  oldest
);

    logic signed [euwv_pkg::DELTA_W-1:0] link [euwv_pkg::WINDOW+1];

    assign link[0] = delta_in;

    for (genvar i = 0; i < euwv_pkg::WINDOW; i++)
    begin : g_cell
        euwv_cell u_cell (
            .clk       (clk),
            .shift     (shift),
            .delta_in  (link[i]),
            .delta_out (link[i+1])
        );
    end

    assign oldest = link[euwv_pkg::WINDOW];

endmodule

FILE: rtl/encoder_unwrap_window_velocity.sv
// Multi-turn angle unwrapper with a moving-window velocity, in encoder counts.
// The sample channel (sample_valid, sample_stall, raw_sample) takes one 12-bit
// absolute angle word per cycle unless stalled. The result channel
// (result_valid, result_stall) returns one word per sample: turn_angle,
// step_delta, window_sum and velocity. The first sample after reset seeds the
// angle and gives a zero delta. Samples are registered in the first stage, then
// in the result stage; the block sustains one word per cycle unless the receiver
// stalls. The window is a shift chain of delta cells that moves once per
// accepted sample; the oldest cell leaves the sum once the chain is full. A
// second stage multiplies the sum by velocity_scale. When the receiver stalls,
// the result word holds and one more sample may be taken into the first stage;
// after that sample_stall rises. Reset clears the angle, the window fill and the
// sum, and sets velocity_scale to 200. velocity_scale is written through the APB
// port at address 0 and should be changed only while no words are in flight.
module encoder_unwrap_window_velocity (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [euwv_pkg::ADDR_W-1:0]           paddr,
    input  logic [euwv_pkg::DATA_W-1:0]           pwdata,
    output logic [euwv_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic [euwv_pkg::SAMPLE_W-1:0]         raw_sample,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [euwv_pkg::ANGLE_W-1:0]   turn_angle,
    output logic signed [euwv_pkg::DELTA_W-1:0]   step_delta,
    output logic signed [euwv_pkg::WSUM_W-1:0]    window_sum,
    output logic signed [euwv_pkg::VEL_W-1:0]     velocity
);

    logic [euwv_pkg::SCALE_W-1:0]         scale_reg;
    logic                                 started_reg;
    logic [euwv_pkg::SAMPLE_W-1:0]        prev_reg;
    logic signed [euwv_pkg::ANGLE_W-1:0]  turn_pos_reg;
    logic signed [euwv_pkg::ANGLE_W-1:0]  turn_pos_next;
    logic signed [euwv_pkg::SUM_W-1:0]    total_reg;
    logic signed [euwv_pkg::SUM_W-1:0]    total_next;
    logic [euwv_pkg::FILL_W-1:0]          fill_reg;
    logic signed [euwv_pkg::DELTA_W-1:0]  delta_reg;
    logic signed [euwv_pkg::DELTA_W-1:0]  delta_next;
    logic signed [euwv_pkg::DELTA_W-1:0]  oldest;
    logic                                 s1_valid_reg;
    logic                                 out_valid_reg;
    logic signed [euwv_pkg::ANGLE_W-1:0]  out_turn_reg;
    logic signed [euwv_pkg::DELTA_W-1:0]  out_delta_reg;
    logic signed [euwv_pkg::WSUM_W-1:0]   out_wsum_reg;
    logic signed [euwv_pkg::VEL_W-1:0]    out_vel_reg;
    logic signed [euwv_pkg::PROD_W-1:0]   product;
    logic                                 full;
    logic                                 accept;
    logic                                 advance;
    logic                                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == euwv_pkg::REG_VELOCITY_SCALE)
                     ? euwv_pkg::DATA_W'(scale_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= euwv_pkg::SCALE_W'(euwv_pkg::SCALE_RESET);
        end
        else if (cfg_write && paddr[2] == euwv_pkg::REG_VELOCITY_SCALE)
        begin
            scale_reg <= pwdata[euwv_pkg::SCALE_W-1:0];
        end
    end

    assign advance      = !out_valid_reg || !result_stall;
    assign sample_stall = s1_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;
    assign full         = (fill_reg == euwv_pkg::FILL_W'(euwv_pkg::WINDOW));

    always_comb
    begin
        if (started_reg)
        begin
            delta_next    = euwv_pkg::wrap_delta(raw_sample, prev_reg);
            turn_pos_next = euwv_pkg::sat_angle(turn_pos_reg, delta_next);
        end
        else
        begin
            delta_next    = '0;
            turn_pos_next = $signed(euwv_pkg::ANGLE_W'(raw_sample));
        end
        total_next = total_reg + euwv_pkg::SUM_W'(delta_next);
        if (full)
        begin
            total_next = total_next - euwv_pkg::SUM_W'(oldest);
        end
    end

    euwv_chain u_chain (
        .clk      (clk),
        .shift    (accept),
        .delta_in (delta_next),
        .oldest   (oldest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            prev_reg     <= '0;
            turn_pos_reg <= '0;
            total_reg    <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                started_reg  <= 1'b1;
                prev_reg     <= raw_sample;
                turn_pos_reg <= turn_pos_next;
                total_reg    <= total_next;
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            delta_reg <= delta_next;
        end
    end

    assign product = euwv_pkg::PROD_W'(total_reg)
                   * $signed(euwv_pkg::PROD_W'(scale_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_turn_reg  <= turn_pos_reg;
            out_delta_reg <= delta_reg;
            out_wsum_reg  <= euwv_pkg::sat_wsum(total_reg);
            out_vel_reg   <= euwv_pkg::sat_vel(product);
        end
    end

    assign result_valid = out_valid_reg;
    assign turn_angle   = out_turn_reg;
    assign step_delta   = out_delta_reg;
    assign window_sum   = out_wsum_reg;
    assign velocity     = out_vel_reg;

endmodule

FILE: rtl/euwv_checker.sv
`include "encoder_unwrap_window_velocity_assert.svh"

module euwv_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  result_valid,
    input  logic                                  result_stall,
    input  logic signed [euwv_pkg::ANGLE_W-1:0]   turn_angle,
    input  logic signed [euwv_pkg::DELTA_W-1:0]   step_delta,
    input  logic signed [euwv_pkg::WSUM_W-1:0]    window_sum,
    input  logic signed [euwv_pkg::VEL_W-1:0]     velocity
);

    // A stalled result word keeps its value.
    `EUWV_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall,
        result_valid && $stable(turn_angle) && $stable(velocity))

    // The folded delta stays within half a turn.
    `EUWV_ASSERT_IMPLY(a_delta_range, clk, rst_n, result_valid,
        step_delta >= -13'sd2048 && step_delta <= 13'sd2048)

    // A zero window sum gives zero velocity.
    `EUWV_ASSERT_IMPLY(a_vel_zero, clk, rst_n, result_valid && window_sum == '0,
        velocity == '0)

    // A non-negative window sum never gives a negative velocity.
    `EUWV_ASSERT_IMPLY(a_vel_sign, clk, rst_n, result_valid && window_sum[15] == 1'b0,
        velocity[24] == 1'b0)

endmodule

bind encoder_unwrap_window_velocity euwv_checker u_euwv_checker (.*);

FILE: tb/encoder_unwrap_window_velocity_test.sv
module encoder_unwrap_window_velocity_test;

    timeunit 1ns;
    timeprecision 1ps;

    import euwv_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam logic [ADDR_W-1:0] SCALE_ADDR = ADDR_W'(4 * int'(REG_VELOCITY_SCALE));
    localparam longint ANGLE_MAX = 64'sd2147483647;
    localparam longint ANGLE_MIN = -64'sd2147483648;
    localparam longint WSUM_MAX = (64'sd1 <<< (WSUM_W - 1)) - 1;
    localparam longint WSUM_MIN = -(64'sd1 <<< (WSUM_W - 1));
    localparam longint VEL_MAX = (64'sd1 <<< (VEL_W - 1)) - 1;
    localparam longint VEL_MIN = -(64'sd1 <<< (VEL_W - 1));

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [DELTA_W-1:0] delta;
        logic signed [WSUM_W-1:0]  wsum;
        logic signed [VEL_W-1:0]   vel;
    } motion_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       sample_valid;
    logic                       sample_stall;
    logic [SAMPLE_W-1:0]        raw_sample;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [ANGLE_W-1:0]  turn_angle;
    logic signed [DELTA_W-1:0]  step_delta;
    logic signed [WSUM_W-1:0]   window_sum;
    logic signed [VEL_W-1:0]    velocity;

    motion_word_t expected_words[$];
    int mismatches = 0;
    int cycle_count = 0;

    // Encoder state as the block should hold it.
    logic                seeded = 1'b0;
    logic [SAMPLE_W-1:0] last_raw = '0;
    int                  unwrapped_angle = 0;
    int                  delta_hist[WINDOW];
    int                  hist_ptr = 0;
    int                  hist_count = 0;
    int                  hist_total = 0;
    logic [SCALE_W-1:0]  scale_reg = SCALE_W'(SCALE_RESET);

    // Sender and receiver idling controls.
    logic [SAMPLE_W-1:0] last_sent = '0;
    int gap_max = 0;
    int burst_max = 1;
    int burst_left = 0;
    int stall_pct = 0;
    int stall_run = 0;
    int hold_off_len = 0;
    int hold_left = 0;

    encoder_unwrap_window_velocity dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .raw_sample   (raw_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .turn_angle   (turn_angle),
        .step_delta   (step_delta),
        .window_sum   (window_sum),
        .velocity     (velocity)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic motion_word_t advance_encoder(input logic [SAMPLE_W-1:0] raw);
        int           move;
        longint       angle_next;
        longint       wsum;
        longint       speed;
        motion_word_t w;
        if (!seeded)
        begin
            last_raw = raw;
            unwrapped_angle = int'(raw);
            seeded = 1'b1;
        end
        move = int'(raw) - int'(last_raw);
        if (move < -HALF_TURN)
        begin
            move += TURN;
        end
        else if (move > HALF_TURN)
        begin
            move -= TURN;
        end
        angle_next = longint'(unwrapped_angle) + move;
        if (angle_next > ANGLE_MAX)
        begin
            angle_next = ANGLE_MAX;
        end
        else if (angle_next < ANGLE_MIN)
        begin
            angle_next = ANGLE_MIN;
        end
        unwrapped_angle = int'(angle_next);
        last_raw = raw;
        if (hist_count >= WINDOW)
        begin
            hist_total -= delta_hist[hist_ptr];
        end
        else
        begin
            hist_count++;
        end
        delta_hist[hist_ptr] = move;
        hist_ptr = (hist_ptr + 1) % WINDOW;
        hist_total += move;
        wsum = hist_total;
        if (wsum > WSUM_MAX)
        begin
            wsum = WSUM_MAX;
        end
        else if (wsum < WSUM_MIN)
        begin
            wsum = WSUM_MIN;
        end
        speed = longint'(hist_total) * longint'(scale_reg);
        if (speed > VEL_MAX)
        begin
            speed = VEL_MAX;
        end
        else if (speed < VEL_MIN)
        begin
            speed = VEL_MIN;
        end
        w.angle = unwrapped_angle;
        w.delta = DELTA_W'(move);
        w.wsum = WSUM_W'(wsum);
        w.vel = VEL_W'(speed);
        return w;
    endfunction

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        motion_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, actual %0d %0d %0d %0d",
                         $time, turn_angle, step_delta, window_sum, velocity);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("turn_angle", want.angle, turn_angle);
                check_field("step_delta", want.delta, step_delta);
                check_field("window_sum", want.wsum, window_sum);
                check_field("velocity", want.vel, velocity);
            end
        end
    end

    // The receiver stalls in random runs, or holds off for a requested number of cycles.
    always @(negedge clk)
    begin
        if (hold_off_len != 0)
        begin
            hold_left = hold_off_len;
            hold_off_len = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_run == 0)
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
            stall_run = $urandom_range(1, 6);
        end
        else
        begin
            stall_run--;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(gap_max);
            burst_left = $urandom_range(1, burst_max);
            if (gap != 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        raw_sample <= raw;
        do
            @(posedge clk);
        while (sample_stall);
        expected_words.push_back(advance_encoder(raw));
        last_sent = raw;
        @(negedge clk);
    endtask

    task automatic drain_results;
        sample_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic program_velocity_scale(input logic [SCALE_W-1:0] value);
        logic [DATA_W-1:0] readback;
        drain_results();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= SCALE_ADDR;
        pwdata <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        scale_reg = value;
        if (readback !== DATA_W'(value))
        begin
            $display("%0t ns: velocity_scale readback mismatch, expected %0d, actual %0d",
                     $time, value, readback);
            mismatches++;
        end
    endtask

    task automatic send_ramp(input int move, input int count);
        repeat (count) send_sample(last_sent + SAMPLE_W'(move));
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return SAMPLE_W'($urandom_range(TURN - 1));
        end
        else if (r < 70)
        begin
            return last_sent + SAMPLE_W'($urandom_range(128) - 64);
        end
        else if (r < 90)
        begin
            return last_sent + SAMPLE_W'(HALF_TURN - 8 + $urandom_range(16));
        end
        return last_sent + SAMPLE_W'($urandom_range(1) ? 2047 : -2047);
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_sample(pick_sample());
    endtask

    task automatic test_seed_and_wrap_cases;
        gap_max = 2;
        burst_max = 4;
        stall_pct = 20;
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2047);
        send_sample(12'd4095);
        send_sample(12'd2046);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_ramp(2047, 8);
        send_ramp(-2047, 8);
    endtask

    task automatic test_scale_extremes;
        logic [SCALE_W-1:0] scales[4];
        scales = '{10'd1023, 10'd0, 10'd1, 10'd1000};
        foreach (scales[i])
        begin
            program_velocity_scale(scales[i]);
            send_ramp(2047, 8);
            send_ramp(-2047, 8);
            send_random(8);
        end
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < 6; phase++)
        begin
            program_velocity_scale(SCALE_W'($urandom_range(1, 1000)));
            if (phase == 0)
            begin
                gap_max = 0;
                burst_max = 1;
                stall_pct = 0;
            end
            else
            begin
                gap_max = $urandom_range(0, 12);
                burst_max = $urandom_range(1, 20);
                stall_pct = $urandom_range(0, 60);
            end
            send_random(130);
        end
    endtask

    task automatic test_receiver_hold_off;
        drain_results();
        gap_max = 0;
        burst_max = 1;
        stall_pct = 0;
        hold_off_len = 100;
        send_random(40);
        drain_results();
    endtask

    task automatic test_full_rate;
        gap_max = 0;
        burst_max = 1;
        stall_pct = 0;
        send_random(150);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_valid = 1'b0;
        raw_sample = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_seed_and_wrap_cases();
        test_scale_extremes();
        test_random_traffic();
        test_receiver_hold_off();
        test_full_rate();
        drain_results();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/euwv_pkg.sv
rtl/euwv_cell.sv
rtl/euwv_chain.sv
rtl/encoder_unwrap_window_velocity.sv
rtl/euwv_checker.sv
tb/encoder_unwrap_window_velocity_test.sv
